@@ rtl/core/frcr_pkg.sv @@
`default_nettype none

package frcr_pkg;

  localparam int KEY_W        = 32;
  localparam int REQ_W        = 2;
  localparam int CFG_W        = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_COMMIT,
    S_OLD,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic rd_head;
    logic scan;
    logic commit;
    logic rd_old;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t req;
    logic occ_zero;
    logic scan_last;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/frcr_in_if.sv @@
`default_nettype none

interface frcr_in_if;
  import frcr_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] content_key;

  modport source (output valid, output req_type, output content_key, input ready);
  modport sink   (input valid, input req_type, input content_key, output ready);
endinterface

`default_nettype wire

@@ rtl/core/frcr_out_if.sv @@
`default_nettype none

interface frcr_out_if;
  import frcr_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic             evict_valid;
  logic [KEY_W-1:0] evicted_key;
  logic             evicted_was_last;
  logic             cache_full;
  logic [KEY_W-1:0] oldest_key;

  modport source (output valid, output hit, output evict_valid, output evicted_key,
                  output evicted_was_last, output cache_full, output oldest_key,
                  input ready);
  modport sink   (input valid, input hit, input evict_valid, input evicted_key,
                  input evicted_was_last, input cache_full, input oldest_key,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/frcr_cfg_if.sv @@
`default_nettype none

interface frcr_cfg_if;
  import frcr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/frcr_ram.sv @@
`default_nettype none

module frcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/frcr_ctrl.sv @@
`default_nettype none

module frcr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire frcr_pkg::stat_t stat,
  output frcr_pkg::cmd_t       cmd
);
  import frcr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (stat.req == REQ_LOOKUP || stat.req == REQ_STORE) begin
          cmd.rd_head = 1'b1;
          state_nxt   = stat.occ_zero ? S_COMMIT : S_SCAN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OLD;
      end
      S_OLD: begin
        cmd.rd_old = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/core/frcr_dpath.sv @@
`default_nettype none

module frcr_dpath #(
  parameter int CAPACITY = frcr_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = frcr_pkg::KEY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [frcr_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic [frcr_pkg::REQ_W-1:0]  in_req_type,
  input  wire logic [frcr_pkg::KEY_W-1:0]  in_content_key,
  input  wire frcr_pkg::cmd_t              cmd,
  output frcr_pkg::stat_t                  stat,
  output logic                             out_hit,
  output logic                             out_evict_valid,
  output logic [frcr_pkg::KEY_W-1:0]       out_evicted_key,
  output logic                             out_evicted_was_last,
  output logic                             out_cache_full,
  output logic [frcr_pkg::KEY_W-1:0]       out_oldest_key
);
  import frcr_pkg::*;

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  localparam logic [IW-1:0]   LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW:0]     CAP_EXT   = (CW + 1)'(CAPACITY);
  localparam logic [CMPW-1:0] CAP_CMP   = CMPW'(CAPACITY);

  logic [CFG_W-1:0] cfg_r;
  logic [IW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    occ_r, occ_nxt;
  logic [CW-1:0]    dist_r, dist_nxt;
  req_t             req_r;
  logic [KW-1:0]    key_r;
  logic [IW-1:0]    ptr_r;
  logic [IW-1:0]    off_r;
  logic [KW-1:0]    ev_key_r;
  logic             hit_r;
  logic             ev_other_r;

  logic             res_hit_r, res_ev_r, res_last_r;
  logic [KW-1:0]    res_key_r;

  logic [CW-1:0]    cap_eff;
  logic [IW-1:0]    ptr_inc, head_inc;
  logic [CW:0]      tail_sum;
  logic [IW-1:0]    tail_slot;
  logic             evict, ev_last, is_store;
  logic [CW:0]      dist_wide;

  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_raddr;
  logic [KW-1:0]    ram_rdata;

  // clamp the capacity register to 1..CAPACITY
  always_comb begin
    if (cfg_r == '0) begin
      cap_eff = CW'(1);
    end else if (CMPW'(cfg_r) > CAP_CMP) begin
      cap_eff = CW'(CAPACITY);
    end else begin
      cap_eff = CW'(cfg_r);
    end
  end

  assign ptr_inc  = (ptr_r == LAST_SLOT) ? '0 : ptr_r + IW'(1);
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + IW'(1);

  // tail slot: head + occupancy modulo CAPACITY, sum stays below twice it
  assign tail_sum  = (CW + 1)'(head_r) + (CW + 1)'(occ_r);
  assign tail_slot = (tail_sum >= CAP_EXT) ? IW'(tail_sum - CAP_EXT) : IW'(tail_sum);

  assign is_store = (req_r == REQ_STORE);
  assign evict    = is_store && (occ_r >= cap_eff);
  assign ev_last  = evict && !ev_other_r && (key_r != ev_key_r);

  always_comb begin
    head_nxt  = head_r;
    occ_nxt   = occ_r;
    dist_nxt  = dist_r;
    dist_wide = (CW + 1)'(dist_r);
    if (cmd.commit) begin
      unique case (req_r)
        REQ_STORE: begin
          head_nxt  = evict ? head_inc : head_r;
          occ_nxt   = evict ? occ_r : occ_r + CW'(1);
          dist_wide = hit_r ? (CW + 1)'(dist_r) : (CW + 1)'(dist_r) + (CW + 1)'(1);
          if (ev_last && dist_wide != '0) begin
            dist_wide = dist_wide - (CW + 1)'(1);
          end
          dist_nxt = CW'(dist_wide);
        end
        REQ_FLUSH: begin
          head_nxt = '0;
          occ_nxt  = '0;
          dist_nxt = '0;
        end
        default: begin
          head_nxt = head_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= CFG_RESET;
      head_r <= '0;
      occ_r  <= '0;
      dist_r <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
      dist_r <= dist_nxt;
    end
  end

  // item, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r      <= req_t'(in_req_type);
      key_r      <= in_content_key[KW-1:0];
      hit_r      <= 1'b0;
      ev_other_r <= 1'b0;
    end
    if (cmd.rd_head) begin
      ptr_r <= head_r;
      off_r <= '0;
    end
    if (cmd.scan) begin
      ptr_r <= ptr_inc;
      off_r <= off_r + IW'(1);
      if (ram_rdata == key_r) begin
        hit_r <= 1'b1;
      end
      if (off_r == '0) begin
        ev_key_r <= ram_rdata;
      end else if (ram_rdata == ev_key_r) begin
        ev_other_r <= 1'b1;
      end
    end
    if (cmd.commit) begin
      res_hit_r  <= (req_r == REQ_LOOKUP || req_r == REQ_STORE) ? hit_r : 1'b0;
      res_ev_r   <= evict;
      res_key_r  <= evict ? ev_key_r : '0;
      res_last_r <= ev_last;
    end
    if (cmd.load_out) begin
      out_hit              <= res_hit_r;
      out_evict_valid      <= res_ev_r;
      out_evicted_key      <= KEY_W'(res_key_r);
      out_evicted_was_last <= res_last_r;
      out_cache_full       <= (dist_r == cap_eff);
      out_oldest_key       <= (occ_r != '0) ? KEY_W'(ram_rdata) : '0;
    end
  end

  assign ram_we = cmd.commit && is_store;
  assign ram_re = cmd.rd_head || cmd.scan || cmd.rd_old;

  always_comb begin
    if (cmd.scan) begin
      ram_raddr = ptr_inc;
    end else begin
      ram_raddr = head_r;
    end
  end

  frcr_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_slot),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.req       = req_r;
  assign stat.occ_zero  = (occ_r == '0);
  assign stat.scan_last = ((CW'(off_r) + CW'(1)) == occ_r);

endmodule

`default_nettype wire

@@ rtl/core/fifo_replacement_cache_with_replicas.sv @@
// FIFO-replacement content cache with replicas.
//
// Channels: in_chan carries one request transaction (req_type: lookup, store,
// flush; content_key). out_chan returns exactly one result transaction per
// request. cfg_chan writes capacity_in_use (always ready); write it only while
// the block is idle. Zero acts as one, values above CAPACITY act as CAPACITY.
//
// Timing: a request is taken in the idle state. The ring head is read, then
// every occupied slot is read from the key ring RAM, one slot per cycle, and
// compared against the request key and the head key. A commit cycle updates
// head, occupancy and the distinct-key count and writes a stored key at the
// tail; one more read fetches the new head. Flush and the unused request code
// skip the head read and the scan. The result is then loaded into the output
// register from the last state; the next request is accepted only back in the
// idle state. The single read port of the ring RAM limits the scan rate.
//
// Reset clears head, occupancy and key count and sets capacity_in_use to 64;
// the ring RAM is not cleared; data read from unoccupied slots is never used.
// When out_chan stalls, the result holds in the output register and the
// finished next result waits in the last state until that register frees.
`default_nettype none

module fifo_replacement_cache_with_replicas #(
  parameter int CAPACITY = frcr_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = frcr_pkg::KEY_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  frcr_in_if.sink    in_chan,
  frcr_out_if.source out_chan,
  frcr_cfg_if.sink   cfg_chan
);
  import frcr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // configuration writes are taken at any time
  assign cfg_chan.ready = 1'b1;

  frcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frcr_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_chan.valid),
    .cfg_data             (cfg_chan.data),
    .in_req_type          (in_chan.req_type),
    .in_content_key       (in_chan.content_key),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_hit              (out_chan.hit),
    .out_evict_valid      (out_chan.evict_valid),
    .out_evicted_key      (out_chan.evicted_key),
    .out_evicted_was_last (out_chan.evicted_was_last),
    .out_cache_full       (out_chan.cache_full),
    .out_oldest_key       (out_chan.oldest_key)
  );

endmodule

`default_nettype wire
